@@ hw/rtl/capped_lennard_jones_force_accum_core_assert.svh @@
// assertion macros for the capped lennard-jones force core
// needs clk and rst_n in the scope where a macro is used
`ifndef CAPPED_LENNARD_JONES_FORCE_ACCUM_CORE_ASSERT_SVH
`define CAPPED_LENNARD_JONES_FORCE_ACCUM_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CFR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cfr assertion failed");
`define CFR_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("cfr assertion failed");
`else
`define CFR_ASSERT(lbl, prop)
`define CFR_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ hw/rtl/cfr_pkg.sv @@
// shared types and constants of the capped lennard-jones force core
// no dependencies
package cfr_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int FIFO_DEPTH_DEF = 4;
    localparam int ACC_W          = 48;
    localparam int EXT_W          = 66;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_Z      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_RADIUS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_CAP  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IMMOBILE   = 3'd6;

    localparam logic [23:0] EPSILON_RST   = 24'd33554;
    localparam logic [23:0] FORCE_CAP_RST = 24'd32768;

    localparam logic [63:0] INV_LJ2_Q32 = 64'd3408917802;
    localparam logic [63:0] ONE_Q32     = 64'h0000_0001_0000_0000;
    localparam logic [63:0] DIV_SAT     = 64'h8000_0000_0000_0000;

    typedef enum logic [1:0] {
        CLS_FORCE,
        CLS_ZERO,
        CLS_IMMOBILE
    } cls_t;

    typedef enum logic [1:0] {
        SH_0,
        SH_24,
        SH_32
    } mul_sh_t;

    typedef struct packed {
        logic signed [31:0] own_x;
        logic signed [31:0] own_y;
        logic signed [31:0] own_z;
        logic [23:0]        own_radius;
        logic [23:0]        epsilon;
        logic [23:0]        force_cap;
        logic               immobile;
    } cfg_t;

    typedef struct packed {
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
        logic [63:0]      d2;
        logic [24:0]      rsum;
        logic             first;
        cls_t             cls;
    } item_t;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
        mul_sh_t     sh;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } mul_rsp_t;

    typedef struct packed {
        logic        start;
        logic [63:0] n;
        logic [63:0] d;
        logic [5:0]  sh;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } div_rsp_t;

endpackage

@@ hw/rtl/cfr_if.sv @@
// request channels of the force core: neighbour in, running sum out
// no dependencies
interface cfr_nb_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] nb_x;
    logic signed [31:0] nb_y;
    logic signed [31:0] nb_z;
    logic [23:0]        nb_radius;
    logic               first_of_list;

    modport source (output valid, nb_x, nb_y, nb_z, nb_radius, first_of_list, input ready);
    modport sink (input valid, nb_x, nb_y, nb_z, nb_radius, first_of_list, output ready);
endinterface

interface cfr_res_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] sum_x;
    logic signed [47:0] sum_y;
    logic signed [47:0] sum_z;
    logic               zero_distance;

    modport source (output valid, sum_x, sum_y, sum_z, zero_distance, input ready);
    modport sink (input valid, sum_x, sum_y, sum_z, zero_distance, output ready);
endinterface

@@ hw/rtl/cfr_mul.sv @@
// shared 64x64 multiplier, one 32x32 partial product per cycle, shift and saturate
// depends on cfr_pkg
module cfr_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  cfr_pkg::mul_req_t req,
    output cfr_pkg::mul_rsp_t rsp
);
    import cfr_pkg::*;

    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [127:0] acc_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [63:0]  res_reg;
    mul_sh_t      sh_reg;

    logic [31:0]  ap;
    logic [31:0]  bp;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [127:0] acc_next;
    logic [63:0]  fin;
    logic         sat;

    always_comb
    begin
        ap = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
        bp = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
        pp = {32'b0, ap} * {32'b0, bp};
        unique case ({1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]})
            2'd0:    pp_sh = {64'b0, pp};
            2'd1:    pp_sh = {32'b0, pp, 32'b0};
            default: pp_sh = {pp, 64'b0};
        endcase
        acc_next = acc_reg + pp_sh;
        unique case (sh_reg)
            SH_0:
            begin
                sat = |acc_reg[127:64];
                fin = acc_reg[63:0];
            end
            SH_24:
            begin
                sat = |acc_reg[127:88];
                fin = acc_reg[87:24];
            end
            default:
            begin
                sat = |acc_reg[127:96];
                fin = acc_reg[95:32];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 3'd4);
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 3'd4)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            sh_reg  <= req.sh;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 3'd4)
            begin
                res_reg <= sat ? '1 : fin;
            end
            else
            begin
                acc_reg <= acc_next;
            end
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

@@ hw/rtl/cfr_div.sv @@
// shared restoring divider, one quotient bit per cycle, floor(n * 2^s / d)
// saturates at 2^63; depends on cfr_pkg
module cfr_div (
    input  logic              clk,
    input  logic              rst_n,
    input  cfr_pkg::div_req_t req,
    output cfr_pkg::div_rsp_t rsp
);
    import cfr_pkg::*;

    logic [63:0] n_reg;
    logic [63:0] d_reg;
    logic [63:0] rem_reg;
    logic [63:0] q_reg;
    logic        ovf_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [64:0] trial;
    logic [64:0] diff;
    logic        ge;
    logic [6:0]  idx;

    always_comb
    begin
        idx   = cnt_reg - 7'd1;
        trial = {rem_reg, n_reg[63]};
        diff  = trial - {1'b0, d_reg};
        ge    = trial >= {1'b0, d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (idx == 7'd0);
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64 + {1'b0, req.sh};
            end
            else if (busy_reg)
            begin
                cnt_reg <= idx;
                if (idx == 7'd0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            n_reg   <= req.n;
            d_reg   <= req.d;
            rem_reg <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            n_reg   <= {n_reg[62:0], 1'b0};
            rem_reg <= ge ? diff[63:0] : trial[63:0];
            q_reg   <= {q_reg[62:0], ge};
            ovf_reg <= ovf_reg | (ge && (idx >= 7'd63));
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = ovf_reg ? DIV_SAT : q_reg;

endmodule

@@ hw/rtl/cfr_front.sv @@
// front end: takes neighbour requests, forms offsets, squared distance and class
// three pipeline stages; depends on cfr_pkg and cfr_if
module cfr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  cfr_pkg::cfg_t       cfg,
    cfr_nb_if.sink              nb,
    output cfr_pkg::item_t      item,
    output logic                item_valid,
    input  logic                item_ready,
    output logic                busy
);
    import cfr_pkg::*;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic en1;
    logic en2;
    logic en3;

    logic [2:0][31:0] mag1_reg;
    logic [2:0]       neg1_reg;
    logic [24:0]      rsum1_reg;
    logic             first1_reg;
    logic             imm1_reg;

    logic [2:0][63:0] sq2_reg;
    logic [2:0][31:0] mag2_reg;
    logic [2:0]       neg2_reg;
    logic [24:0]      rsum2_reg;
    logic             first2_reg;
    logic             imm2_reg;

    item_t            item3_reg;

    logic [2:0][32:0] dp;
    logic [2:0][31:0] mag_next;
    logic [65:0]      sum;
    logic [63:0]      d2_next;

    always_comb
    begin
        dp[0] = {nb.nb_x[31], nb.nb_x} - {cfg.own_x[31], cfg.own_x};
        dp[1] = {nb.nb_y[31], nb.nb_y} - {cfg.own_y[31], cfg.own_y};
        dp[2] = {nb.nb_z[31], nb.nb_z} - {cfg.own_z[31], cfg.own_z};
        for (int a = 0; a < 3; a++)
        begin
            mag_next[a] = dp[a][32] ? 32'(-dp[a]) : dp[a][31:0];
        end
        sum = {2'b0, sq2_reg[0]} + {2'b0, sq2_reg[1]} + {2'b0, sq2_reg[2]};
        d2_next = (|sum[65:64]) ? '1 : sum[63:0];
    end

    assign en3 = !v3_reg || item_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= nb.valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            mag1_reg   <= mag_next;
            neg1_reg   <= {dp[2][32], dp[1][32], dp[0][32]};
            rsum1_reg  <= {1'b0, cfg.own_radius} + {1'b0, nb.nb_radius};
            first1_reg <= nb.first_of_list;
            imm1_reg   <= cfg.immobile;
        end
        if (en2)
        begin
            for (int a = 0; a < 3; a++)
            begin
                sq2_reg[a] <= {32'b0, mag1_reg[a]} * {32'b0, mag1_reg[a]};
            end
            mag2_reg   <= mag1_reg;
            neg2_reg   <= neg1_reg;
            rsum2_reg  <= rsum1_reg;
            first2_reg <= first1_reg;
            imm2_reg   <= imm1_reg;
        end
        if (en3)
        begin
            item3_reg.mag   <= mag2_reg;
            item3_reg.neg   <= neg2_reg;
            item3_reg.d2    <= d2_next;
            item3_reg.rsum  <= rsum2_reg;
            item3_reg.first <= first2_reg;
            if (imm2_reg)
            begin
                item3_reg.cls <= CLS_IMMOBILE;
            end
            else if (d2_next == '0)
            begin
                item3_reg.cls <= CLS_ZERO;
            end
            else
            begin
                item3_reg.cls <= CLS_FORCE;
            end
        end
    end

    assign nb.ready   = en1;
    assign item       = item3_reg;
    assign item_valid = v3_reg;
    assign busy       = v1_reg | v2_reg | v3_reg;

endmodule

@@ hw/rtl/cfr_fifo.sv @@
// short register queue between front and back end
// depends on cfr_pkg
module cfr_fifo #(
    parameter int DEPTH = cfr_pkg::FIFO_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfr_pkg::item_t         wr_item,
    input  logic                   wr_valid,
    output logic                   wr_ready,
    output cfr_pkg::item_t         rd_item,
    output logic                   rd_valid,
    input  logic                   rd_pop,
    output logic [$clog2(DEPTH):0] count
);
    import cfr_pkg::*;

    localparam int AW = $clog2(DEPTH);

    item_t          mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  rd_ptr_reg;
    logic [AW:0]    count_reg;
    logic           push;
    logic           pop;

    assign wr_ready = count_reg != (AW+1)'(DEPTH);
    assign rd_valid = count_reg != '0;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    assign rd_item = mem_reg[rd_ptr_reg];
    assign count   = count_reg;

endmodule

@@ hw/rtl/cfr_back.sv @@
// back end: square root, force magnitude and saturating accumulation per request
// sequencer over shared cfr_mul and cfr_div; depends on cfr_pkg and cfr_if
module cfr_back #(
    parameter int FRAC_BITS = cfr_pkg::FRAC_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  cfr_pkg::cfg_t  cfg,
    input  cfr_pkg::item_t item,
    input  logic           item_valid,
    output logic           item_pop,
    cfr_res_if.source      res
);
    import cfr_pkg::*;

    localparam logic [63:0] G_LIM = 64'hFFFF_FFFF_FFFF_FFFF / 24;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQRT,
        ST_RR,
        ST_S2,
        ST_CHECK,
        ST_U,
        ST_UU,
        ST_U3,
        ST_M,
        ST_Q,
        ST_H,
        ST_G,
        ST_FM,
        ST_AXD,
        ST_AXM,
        ST_ACC,
        ST_OUT
    } state_t;

    state_t           state_reg;
    logic             issued_reg;
    item_t            it_reg;
    logic [5:0]       sq_cnt_reg;
    logic [63:0]      sq_sh_reg;
    logic [50:0]      sq_rem_reg;
    logic [47:0]      root_reg;
    logic [63:0]      s2_reg;
    logic [63:0]      u_reg;
    logic [63:0]      t_reg;
    logic [63:0]      fmag_reg;
    logic             rep_reg;
    logic [1:0]       ax_reg;
    logic             zero_reg;
    logic [2:0][47:0] sum_reg;
    logic             out_valid_reg;
    logic [2:0][47:0] out_sum_reg;
    logic             out_zero_reg;

    mul_req_t         mul_req;
    mul_rsp_t         mul_rsp;
    div_req_t         div_req;
    div_rsp_t         div_rsp;

    logic [63:0]      dq;
    logic [63:0]      capq;
    logic             is_mul;
    logic             is_div;
    logic             op_done;
    logic [50:0]      rem_sh;
    logic [50:0]      trial;
    logic             sq_ge;
    logic [50:0]      sq_rem_next;
    logic [47:0]      root_next;
    logic [63:0]      two;
    logic             rep_next;
    logic [63:0]      h_next;
    logic [63:0]      g24;
    logic [63:0]      fmag_next;
    logic [63:0]      c_val;
    logic [EXT_W-1:0] cur_ext;
    logic [EXT_W-1:0] acc_sum;
    logic [ACC_W-1:0] acc_next;
    logic             neg_c;

    cfr_mul u_mul (
        .clk (clk),
        .rst_n (rst_n),
        .req (mul_req),
        .rsp (mul_rsp)
    );

    cfr_div u_div (
        .clk (clk),
        .rst_n (rst_n),
        .req (div_req),
        .rsp (div_rsp)
    );

    always_comb
    begin
        dq   = {16'b0, root_reg};
        capq = {40'b0, cfg.force_cap} << (32 - FRAC_BITS);

        mul_req = '0;
        div_req = '0;
        is_mul  = 1'b0;
        is_div  = 1'b0;
        unique case (state_reg)
            ST_RR:
            begin
                is_mul    = 1'b1;
                mul_req.a = {39'b0, it_reg.rsum};
                mul_req.b = {39'b0, it_reg.rsum};
                mul_req.sh = SH_0;
            end
            ST_S2:
            begin
                is_mul    = 1'b1;
                mul_req.a = t_reg;
                mul_req.b = INV_LJ2_Q32;
                mul_req.sh = SH_32;
            end
            ST_UU:
            begin
                is_mul    = 1'b1;
                mul_req.a = u_reg;
                mul_req.b = u_reg;
                mul_req.sh = SH_32;
            end
            ST_U3:
            begin
                is_mul    = 1'b1;
                mul_req.a = t_reg;
                mul_req.b = u_reg;
                mul_req.sh = SH_32;
            end
            ST_M:
            begin
                is_mul    = 1'b1;
                mul_req.a = {40'b0, cfg.epsilon};
                mul_req.b = u_reg;
                mul_req.sh = SH_24;
            end
            ST_G:
            begin
                is_mul    = 1'b1;
                mul_req.a = t_reg;
                mul_req.b = u_reg;
                mul_req.sh = SH_32;
            end
            ST_AXM:
            begin
                is_mul    = 1'b1;
                mul_req.a = fmag_reg;
                mul_req.b = u_reg;
                mul_req.sh = SH_32;
            end
            ST_U:
            begin
                is_div    = 1'b1;
                div_req.n = s2_reg;
                div_req.d = it_reg.d2;
                div_req.sh = 6'd32;
            end
            ST_Q:
            begin
                is_div    = 1'b1;
                div_req.n = t_reg;
                div_req.d = dq;
                div_req.sh = 6'(FRAC_BITS + 16);
            end
            ST_AXD:
            begin
                is_div    = 1'b1;
                div_req.n = {32'b0, it_reg.mag[ax_reg]};
                div_req.d = dq;
                div_req.sh = 6'd48;
            end
            default:
            begin
            end
        endcase
        mul_req.start = is_mul && !issued_reg;
        div_req.start = is_div && !issued_reg;
        op_done = (is_mul && mul_rsp.done) || (is_div && div_rsp.done);

        // one root bit per cycle
        rem_sh      = {sq_rem_reg[48:0], sq_sh_reg[63:62]};
        trial       = {1'b0, root_reg, 2'b01};
        sq_ge       = rem_sh >= trial;
        sq_rem_next = sq_ge ? rem_sh - trial : rem_sh;
        root_next   = {root_reg[46:0], sq_ge};

        two      = {u_reg[62:0], 1'b0};
        rep_next = two >= ONE_Q32;
        h_next   = rep_next ? two - ONE_Q32 : ONE_Q32 - two;

        g24       = (t_reg << 4) + (t_reg << 3);
        fmag_next = (t_reg > G_LIM) ? '1 : g24;
        if (fmag_next > capq)
        begin
            fmag_next = capq;
        end

        c_val   = t_reg >> (32 - FRAC_BITS);
        neg_c   = rep_reg ? !it_reg.neg[ax_reg] : it_reg.neg[ax_reg];
        cur_ext = {{(EXT_W-ACC_W){sum_reg[ax_reg][ACC_W-1]}}, sum_reg[ax_reg]};
        acc_sum = neg_c ? cur_ext - {2'b0, c_val} : cur_ext + {2'b0, c_val};
        if ($signed(acc_sum) > $signed({{(EXT_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}}))
        begin
            acc_next = {1'b0, {(ACC_W-1){1'b1}}};
        end
        else if ($signed(acc_sum) < $signed({{(EXT_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}}))
        begin
            acc_next = {1'b1, {(ACC_W-1){1'b0}}};
        end
        else
        begin
            acc_next = acc_sum[ACC_W-1:0];
        end
    end

    assign item_pop = (state_reg == ST_IDLE) && item_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
        end
        else
        begin
            issued_reg <= (is_mul || is_div) && !op_done;
            if ((state_reg == ST_OUT) && (!out_valid_reg || res.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item_valid)
                    begin
                        if (item.first)
                        begin
                            sum_reg <= '0;
                        end
                        unique case (item.cls)
                            CLS_FORCE:    state_reg <= ST_SQRT;
                            CLS_ZERO:     state_reg <= ST_OUT;
                            CLS_IMMOBILE: state_reg <= ST_OUT;
                            default:      state_reg <= ST_OUT;
                        endcase
                    end
                end
                ST_SQRT:
                begin
                    if (sq_cnt_reg == '0)
                    begin
                        state_reg <= ST_RR;
                    end
                end
                ST_RR:    if (op_done) state_reg <= ST_S2;
                ST_S2:    if (op_done) state_reg <= ST_CHECK;
                ST_CHECK:
                begin
                    if ({8'b0, s2_reg} >= {it_reg.d2, 8'b0})
                    begin
                        state_reg <= ST_AXD;
                    end
                    else
                    begin
                        state_reg <= ST_U;
                    end
                end
                ST_U:     if (op_done) state_reg <= ST_UU;
                ST_UU:    if (op_done) state_reg <= ST_U3;
                ST_U3:    if (op_done) state_reg <= ST_M;
                ST_M:     if (op_done) state_reg <= ST_Q;
                ST_Q:     if (op_done) state_reg <= ST_H;
                ST_H:     state_reg <= ST_G;
                ST_G:     if (op_done) state_reg <= ST_FM;
                ST_FM:    state_reg <= ST_AXD;
                ST_AXD:   if (op_done) state_reg <= ST_AXM;
                ST_AXM:   if (op_done) state_reg <= ST_ACC;
                ST_ACC:
                begin
                    sum_reg[ax_reg] <= acc_next;
                    state_reg       <= (ax_reg == 2'd2) ? ST_OUT : ST_AXD;
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || res.ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                it_reg     <= item;
                zero_reg   <= item.cls == CLS_ZERO;
                sq_cnt_reg <= 6'd47;
                sq_sh_reg  <= item.d2;
                sq_rem_reg <= '0;
                root_reg   <= '0;
                ax_reg     <= '0;
            end
            ST_SQRT:
            begin
                sq_rem_reg <= sq_rem_next;
                root_reg   <= root_next;
                sq_sh_reg  <= {sq_sh_reg[61:0], 2'b00};
                sq_cnt_reg <= sq_cnt_reg - 6'd1;
            end
            ST_RR:    if (op_done) t_reg <= mul_rsp.result;
            ST_S2:    if (op_done) s2_reg <= mul_rsp.result;
            ST_CHECK:
            begin
                rep_reg  <= 1'b1;
                fmag_reg <= (cfg.epsilon != '0) ? capq : '0;
            end
            ST_U:     if (op_done) u_reg <= div_rsp.result;
            ST_UU:    if (op_done) t_reg <= mul_rsp.result;
            ST_U3:    if (op_done) u_reg <= mul_rsp.result;
            ST_M:     if (op_done) t_reg <= mul_rsp.result;
            ST_Q:     if (op_done) t_reg <= div_rsp.result;
            ST_H:
            begin
                rep_reg <= rep_next;
                u_reg   <= h_next;
            end
            ST_G:     if (op_done) t_reg <= mul_rsp.result;
            ST_FM:    fmag_reg <= fmag_next;
            ST_AXD:   if (op_done) u_reg <= div_rsp.result;
            ST_AXM:   if (op_done) t_reg <= mul_rsp.result;
            ST_ACC:   ax_reg <= ax_reg + 2'd1;
            ST_OUT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_sum_reg  <= sum_reg;
                    out_zero_reg <= zero_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res.valid         = out_valid_reg;
    assign res.sum_x         = out_sum_reg[0];
    assign res.sum_y         = out_sum_reg[1];
    assign res.sum_z         = out_sum_reg[2];
    assign res.zero_distance = out_zero_reg;

endmodule

@@ hw/rtl/capped_lennard_jones_force_accum_core.sv @@
// capped lennard-jones pair force accumulator, top level
// path: 3 front stages and the queue, then the back end, timed by the bit-serial
// divider (up to 112 steps per quotient, up to 5 quotients) and the 48-step square root;
// immobile or coincident requests skip both and go from idle straight to the output state
// throughput: one request per back-end pass; up to 7 wait ahead (3 front stages, 4 queued)
// reset: async active low, clears sums and control, loads register defaults
`include "capped_lennard_jones_force_accum_core_assert.svh"
module capped_lennard_jones_force_accum_core #(
    parameter int FRAC_BITS  = cfr_pkg::FRAC_BITS_DEF,
    parameter int FIFO_DEPTH = cfr_pkg::FIFO_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    cfr_nb_if.sink                           nb,
    cfr_res_if.source                        res,
    input  logic                             cfg_we,
    input  logic [cfr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cfr_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import cfr_pkg::*;

    cfg_t                      cfg_reg;
    item_t                     fr_item;
    logic                      fr_valid;
    logic                      fr_ready;
    logic                      fr_busy;
    item_t                     q_item;
    logic                      q_valid;
    logic                      q_pop;
    logic [$clog2(FIFO_DEPTH):0] q_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_x      <= '0;
            cfg_reg.own_y      <= '0;
            cfg_reg.own_z      <= '0;
            cfg_reg.own_radius <= '0;
            cfg_reg.epsilon    <= EPSILON_RST;
            cfg_reg.force_cap  <= FORCE_CAP_RST;
            cfg_reg.immobile   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OWN_X:      cfg_reg.own_x      <= cfg_data;
                CFG_OWN_Y:      cfg_reg.own_y      <= cfg_data;
                CFG_OWN_Z:      cfg_reg.own_z      <= cfg_data;
                CFG_OWN_RADIUS: cfg_reg.own_radius <= cfg_data[23:0];
                CFG_EPSILON:    cfg_reg.epsilon    <= cfg_data[23:0];
                CFG_FORCE_CAP:  cfg_reg.force_cap  <= cfg_data[23:0];
                CFG_IMMOBILE:   cfg_reg.immobile   <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    cfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .nb         (nb),
        .item       (fr_item),
        .item_valid (fr_valid),
        .item_ready (fr_ready),
        .busy       (fr_busy)
    );

    cfr_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_item  (fr_item),
        .wr_valid (fr_valid),
        .wr_ready (fr_ready),
        .rd_item  (q_item),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .count    (q_count)
    );

    cfr_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item       (q_item),
        .item_valid (q_valid),
        .item_pop   (q_pop),
        .res        (res)
    );

    // queue never holds more than its depth
    `CFR_ASSERT(a_queue_bound, q_count <= ($clog2(FIFO_DEPTH)+1)'(FIFO_DEPTH))
    // a coincident flag only comes from a mobile cell
    `CFR_ASSERT(a_zero_mobile, res.valid && res.zero_distance |-> !cfg_reg.immobile)
    // with nothing in flight the front must take a request
    `CFR_ASSERT(a_idle_ready, !fr_busy && q_count == '0 |-> nb.ready)

endmodule
